### rtl/ale_pkg.sv
package ale_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = 5;
	localparam int CMD_W = 4;
	localparam int WORD_W = 32;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 4'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 4'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_REM_HEAD = 4'd3;
	localparam logic [CMD_W-1:0] CMD_REM_TAIL = 4'd4;
	localparam logic [CMD_W-1:0] CMD_REM_POS  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_RD_HEAD  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_RD_TAIL  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RD_POS   = 4'd8;

	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_t;

endpackage

### rtl/ale_ctrl.sv
module ale_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output ale_pkg::ctrl_t ctrl
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.capture = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					ctrl.execute = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.execute) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/ale_dp.sv
module ale_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ale_pkg::ctrl_t                      ctrl,
	input  logic [ale_pkg::CNT_W-1:0]           capacity_limit,
	input  logic [ale_pkg::CMD_W-1:0]           cmd,
	input  logic [ale_pkg::CNT_W-1:0]           position,
	input  logic signed [ale_pkg::WORD_W-1:0]   data_in,
	output logic                                status,
	output logic signed [ale_pkg::WORD_W-1:0]   data_out,
	output logic [ale_pkg::CNT_W-1:0]           count_now,
	output logic                                is_full
);

	logic signed [ale_pkg::WORD_W-1:0] entries_q [ale_pkg::DEPTH];
	logic [ale_pkg::CNT_W-1:0]         count_q;
	logic [ale_pkg::CMD_W-1:0]         cmd_q;
	logic [ale_pkg::CNT_W-1:0]         pos_q;
	logic signed [ale_pkg::WORD_W-1:0] word_q;

	logic                              status_q;
	logic signed [ale_pkg::WORD_W-1:0] data_out_q;
	logic [ale_pkg::CNT_W-1:0]         count_out_q;
	logic                              full_q;

	logic [ale_pkg::CNT_W-1:0]         cap_eff;
	logic [ale_pkg::CNT_W-1:0]         last;
	logic [ale_pkg::CNT_W-1:0]         tpos;
	logic                              is_ins;
	logic                              is_rem;
	logic                              is_rd;
	logic                              ok;
	logic                              do_ins;
	logic                              do_rem;
	logic signed [ale_pkg::WORD_W-1:0] rd_word;
	logic [ale_pkg::CNT_W-1:0]         count_nxt;

	assign cap_eff = (capacity_limit > ale_pkg::CNT_W'(ale_pkg::DEPTH)) ?
		ale_pkg::CNT_W'(ale_pkg::DEPTH) : capacity_limit;
	assign last = count_q - ale_pkg::CNT_W'(1);

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		is_rd = 1'b0;
		tpos = '0;
		unique case (cmd_q)
			ale_pkg::CMD_INS_HEAD: begin
				is_ins = 1'b1;
			end
			ale_pkg::CMD_INS_TAIL: begin
				is_ins = 1'b1;
				tpos = count_q;
			end
			ale_pkg::CMD_INS_POS: begin
				is_ins = 1'b1;
				tpos = pos_q;
			end
			ale_pkg::CMD_REM_HEAD: begin
				is_rem = 1'b1;
			end
			ale_pkg::CMD_REM_TAIL: begin
				is_rem = 1'b1;
				tpos = last;
			end
			ale_pkg::CMD_REM_POS: begin
				is_rem = 1'b1;
				tpos = pos_q;
			end
			ale_pkg::CMD_RD_HEAD: begin
				is_rd = 1'b1;
			end
			ale_pkg::CMD_RD_TAIL: begin
				is_rd = 1'b1;
				tpos = last;
			end
			ale_pkg::CMD_RD_POS: begin
				is_rd = 1'b1;
				tpos = pos_q;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
	end

	// An empty list makes last wrap to the top code, which fails the bound check.
	always_comb begin
		if (is_ins) begin
			ok = (count_q < cap_eff) && (tpos <= count_q);
		end else if (is_rem || is_rd) begin
			ok = (tpos < count_q);
		end else begin
			ok = 1'b0;
		end
	end

	assign do_ins = ctrl.execute && ok && is_ins;
	assign do_rem = ctrl.execute && ok && is_rem;
	assign rd_word = entries_q[tpos[ale_pkg::IDX_W-1:0]];

	always_comb begin
		if (ok && is_ins) begin
			count_nxt = count_q + ale_pkg::CNT_W'(1);
		end else if (ok && is_rem) begin
			count_nxt = count_q - ale_pkg::CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	for (genvar g = 0; g < ale_pkg::DEPTH; g++) begin : g_entry
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (tpos == ale_pkg::CNT_W'(g)) begin
					entries_q[g] <= word_q;
				end else if (g > 0) begin
					if (tpos < ale_pkg::CNT_W'(g)) begin
						entries_q[g] <= entries_q[(g > 0) ? g - 1 : 0];
					end
				end
			end else if (do_rem) begin
				if (g < ale_pkg::DEPTH - 1) begin
					if (tpos <= ale_pkg::CNT_W'(g)) begin
						entries_q[g] <= entries_q[(g < ale_pkg::DEPTH - 1) ? g + 1 : g];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.execute) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= cmd;
			pos_q <= position;
			word_q <= data_in;
		end
		if (ctrl.execute) begin
			status_q <= !ok;
			data_out_q <= (ok && !is_ins) ? rd_word : '0;
			count_out_q <= count_nxt;
			full_q <= (count_nxt >= cap_eff);
		end
	end

	assign status = status_q;
	assign data_out = data_out_q;
	assign count_now = count_out_q;
	assign is_full = full_q;

endmodule

### rtl/array_list_engine.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  cmd, position, data_in
// output   out        out_valid / out_stall status, data_out, count_now, is_full
// config   in         APB write/read       capacity_limit at byte address 0
//
// Each command beat is captured in the idle state; the execute state then updates the list.
// The execute step waits while a previous result is still stalled in the output register.
// The whole list shifts in the execute cycle, so the rate does not depend on position.
// Reset clears the count and the output valid and sets the capacity limit to 16.
// The input is stalled from capture until the result has been loaded.
module array_list_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ale_pkg::CMD_W-1:0]           cmd,
	input  logic [ale_pkg::CNT_W-1:0]           position,
	input  logic signed [ale_pkg::WORD_W-1:0]   data_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic signed [ale_pkg::WORD_W-1:0]   data_out,
	output logic [ale_pkg::CNT_W-1:0]           count_now,
	output logic                                is_full,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	ale_pkg::ctrl_t            ctrl;
	logic [ale_pkg::CNT_W-1:0] capacity_q;
	logic                      reg_hit;

	assign pready = 1'b1;
	assign reg_hit = (paddr[2] == ale_pkg::REG_CAPACITY);
	assign prdata = reg_hit ? {{(32 - ale_pkg::CNT_W){1'b0}}, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ale_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			capacity_q <= pwdata[ale_pkg::CNT_W-1:0];
		end
	end

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	ale_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.capacity_limit (capacity_q),
		.cmd            (cmd),
		.position       (position),
		.data_in        (data_in),
		.status         (status),
		.data_out       (data_out),
		.count_now      (count_now),
		.is_full        (is_full)
	);

endmodule
